### hdl/tksi_pkg.sv
// ============================================================================
// tksi_pkg: shared types and constants of the top-K sorted insertion list
// Command codes, entry payload, per-cell control and status, result beat.
// ============================================================================
package tksi_pkg;

  localparam int SlotsDefault     = 16;
  localparam int ScoreBitsDefault = 32;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  // Payload carried with every entry; the score travels apart because its
  // width is a module parameter.
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  market;
    logic [31:0] price;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic clear;
    logic insert;
    logic ascending;
  } cell_ctrl_t;

  // Status each cell hands to its lower neighbor and to the top level.
  typedef struct packed {
    logic valid;
    logic take;
    logic found;
  } cell_stat_t;

  // One result beat.
  typedef struct packed {
    logic        inserted;
    logic [3:0]  position;
    logic        rd_valid;
    entry_t      rd_entry;
    logic [31:0] rd_score;
  } res_t;

endpackage

### hdl/top_k_sorted_insert.sv
// ============================================================================
// top_k_sorted_insert: ranked list of the best SLOTS scored entries
// A row of slot cells with an insertion chain, plus a two-beat result buffer.
// ============================================================================
// Usage
// Commands arrive on the input channel (in_valid_i / in_stall_o): clear all
// slots, insert a candidate (key, market, price, Q16.16 score) or read one
// slot. Every accepted beat yields exactly one result beat on the output
// channel (out_valid_o / out_stall_i), in order.
// For each command the row of cells compares the candidate with every slot
// at once, the "found" flag ripples down the row, and each cell takes the
// candidate, the entry from above, or holds. The result is registered, and
// a new command is accepted every cycle while the receiver keeps up.
// When the receiver stalls, one more beat is taken into a skid register;
// after that in_stall_o rises until the output register drains.
// The ranking order comes from a one-bit register written through the
// cfg_valid_i / cfg_ready_o port, which is always ready; write it only
// while the block is idle. Reset empties the list, marks both result
// registers empty and selects descending order.
// ============================================================================
module top_k_sorted_insert #(
  parameter int SLOTS      = tksi_pkg::SlotsDefault,
  parameter int SCORE_BITS = tksi_pkg::ScoreBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        item_key_i,
  input  logic [7:0]         item_market_i,
  input  logic [31:0]        item_price_i,
  input  logic signed [31:0] item_score_i,
  input  logic [3:0]         read_slot_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inserted_o,
  output logic [3:0]         insert_position_o,
  output logic               slot_valid_out_o,
  output logic [31:0]        slot_key_out_o,
  output logic [7:0]         slot_market_out_o,
  output logic [31:0]        slot_price_out_o,
  output logic signed [31:0] slot_score_out_o
);
  import tksi_pkg::*;

  localparam int IdxW = $clog2(SLOTS);
  // Only the low bits of the incoming score up to 32 are meaningful.
  localparam int InW  = (SCORE_BITS < 32) ? SCORE_BITS : 32;

  // Configuration register.
  logic ascending_q;

  // Cell row.
  cell_ctrl_t                   ctrl;
  entry_t                       cand_entry;
  logic signed [SCORE_BITS-1:0] cand_score;
  cell_stat_t                   stat_w  [SLOTS];
  entry_t                       entry_w [SLOTS];
  logic signed [SCORE_BITS-1:0] score_w [SLOTS];
  logic [SLOTS-1:0]             valid_vec;

  // Command decode and result.
  logic            in_accept;
  logic            out_fire;
  logic            in_range;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] take_pos;
  res_t            res_d;

  // Result buffer: output register plus skid register.
  res_t out_q;
  logic out_valid_q;
  res_t skid_q;
  logic skid_valid_q;

  // --------------------------------------------------------------------------
  // Configuration: always ready, one bit of data.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascending_q <= 1'b0;
    end else if (cfg_valid_i) begin
      ascending_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes. The block stalls only while the skid register is occupied.
  // --------------------------------------------------------------------------
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign ctrl.clear     = in_accept && (cmd_i == CmdClear);
  assign ctrl.insert    = in_accept && (cmd_i == CmdInsert);
  assign ctrl.ascending = ascending_q;

  assign cand_entry.key    = item_key_i;
  assign cand_entry.market = item_market_i;
  assign cand_entry.price  = item_price_i;
  // Keep the low InW bits, read as two's complement, at the stored width.
  assign cand_score        = SCORE_BITS'($signed(item_score_i[InW-1:0]));

  // --------------------------------------------------------------------------
  // Row of cells. Slot 0 sees an empty, not-found neighbor above it.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_stat_t                   prev_stat;
    entry_t                       prev_entry;
    logic signed [SCORE_BITS-1:0] prev_score;

    if (i == 0) begin : g_head
      assign prev_stat  = '0;
      assign prev_entry = '0;
      assign prev_score = '0;
    end else begin : g_body
      assign prev_stat  = stat_w[i-1];
      assign prev_entry = entry_w[i-1];
      assign prev_score = score_w[i-1];
    end

    tksi_cell #(
      .SCORE_BITS (SCORE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cand_entry_i (cand_entry),
      .cand_score_i (cand_score),
      .prev_stat_i  (prev_stat),
      .prev_entry_i (prev_entry),
      .prev_score_i (prev_score),
      .stat_o       (stat_w[i]),
      .entry_o      (entry_w[i]),
      .score_o      (score_w[i])
    );

    assign valid_vec[i] = stat_w[i].valid;
  end

  // At most one cell takes the candidate, so OR-ing the indices gives its slot.
  always_comb begin
    take_pos = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (stat_w[i].take) begin
        take_pos = take_pos | IdxW'(i);
      end
    end
  end

  // Read index: slots at or beyond SLOTS read as empty.
  assign in_range = (32'(read_slot_i) < SLOTS);
  assign rd_idx   = IdxW'(read_slot_i);

  always_comb begin
    res_d = '0;
    case (cmd_i)
      CmdClear: begin
      end
      CmdInsert: begin
        res_d.inserted = stat_w[SLOTS-1].found;
        res_d.position = stat_w[SLOTS-1].found ? 4'(take_pos) : 4'd0;
      end
      CmdRead: begin
        if (in_range && valid_vec[rd_idx]) begin
          res_d.rd_valid = 1'b1;
          res_d.rd_entry = entry_w[rd_idx];
          res_d.rd_score = 32'(score_w[rd_idx]);
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result buffer. A new beat goes to the output register when it is free or
  // draining this cycle, otherwise into the skid register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign inserted_o        = out_q.inserted;
  assign insert_position_o = out_q.position;
  assign slot_valid_out_o  = out_q.rd_valid;
  assign slot_key_out_o    = out_q.rd_entry.key;
  assign slot_market_out_o = out_q.rd_entry.market;
  assign slot_price_out_o  = out_q.rd_entry.price;
  assign slot_score_out_o  = $signed(out_q.rd_score);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid register holds a beat while the output register is empty");

  // Occupied slots always form an unbroken run from slot 0.
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied slots are not contiguous from the top");

  // A clear empties every slot by the next cycle.
  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (valid_vec == '0))
    else $error("list not empty after a clear");

  // An insert into a list that is not full always lands.
  a_insert_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.insert && !valid_vec[SLOTS-1]) |-> stat_w[SLOTS-1].found)
    else $error("insert rejected although a slot was free");

  // An insert result never carries read data.
  a_result_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(inserted_o && slot_valid_out_o))
    else $error("result beat flags both an insert and a read");

endmodule

### hdl/tksi_cell.sv
// ============================================================================
// tksi_cell: one slot of the ranked list
// Holds one entry, compares it with the candidate and either keeps it, takes
// the candidate, takes the entry of the slot above it, or empties on a clear.
// ============================================================================
module tksi_cell #(
  parameter int SCORE_BITS = tksi_pkg::ScoreBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tksi_pkg::cell_ctrl_t          ctrl_i,
  input  tksi_pkg::entry_t              cand_entry_i,
  input  logic signed [SCORE_BITS-1:0]  cand_score_i,
  input  tksi_pkg::cell_stat_t          prev_stat_i,
  input  tksi_pkg::entry_t              prev_entry_i,
  input  logic signed [SCORE_BITS-1:0]  prev_score_i,
  output tksi_pkg::cell_stat_t          stat_o,
  output tksi_pkg::entry_t              entry_o,
  output logic signed [SCORE_BITS-1:0]  score_o
);
  import tksi_pkg::*;

  logic                         valid_q, valid_d;
  entry_t                       entry_q, entry_d;
  logic signed [SCORE_BITS-1:0] score_q, score_d;
  logic                         beats;
  logic                         cond;
  logic                         take;
  logic                         shift;

  // The candidate wins here if the slot is empty or strictly beaten.
  assign beats = ctrl_i.ascending ? (cand_score_i < score_q) : (cand_score_i > score_q);
  assign cond  = !valid_q || beats;
  assign take  = ctrl_i.insert && cond && !prev_stat_i.found;
  assign shift = ctrl_i.insert && prev_stat_i.found;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    score_d = score_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
      entry_d = cand_entry_i;
      score_d = cand_score_i;
    end else if (shift) begin
      valid_d = prev_stat_i.valid;
      entry_d = prev_entry_i;
      score_d = prev_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    score_q <= score_d;
  end

  assign stat_o.valid = valid_q;
  assign stat_o.take  = take;
  assign stat_o.found = prev_stat_i.found || cond;
  assign entry_o      = entry_q;
  assign score_o      = score_q;

endmodule

### sim/top_k_sorted_insert_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// top_k_sorted_insert_tb: self-checking bench for the top-K sorted list
// Drives clear, insert, read and spare commands with random gaps and
// back-pressure. A shadow copy of the ranked list predicts every result beat.
// Each accepted result is compared field by field, in order.
// ============================================================================

localparam int TbSlots = tksi_pkg::SlotsDefault;

// The spare command code has no name in the package.
localparam logic [1:0] CmdSpare = 2'd3;

typedef struct packed {
  logic [1:0]         op;
  tksi_pkg::entry_t   entry;
  logic signed [31:0] score;
  logic [3:0]         slot;
} command_t;

// Shadow of the ranked list plus the queue of result beats it has predicted.
class ranked_list_shadow;
  bit                  ascending;
  bit                  occupied [TbSlots];
  tksi_pkg::entry_t    entry_at [TbSlots];
  logic signed [31:0]  score_at [TbSlots];
  tksi_pkg::res_t      results_due [$];
  int unsigned         mismatches;

  function void set_order(bit asc);
    ascending = asc;
  endfunction

  function int unsigned pending();
    return results_due.size();
  endfunction

  function bit outranks(logic signed [31:0] cand, logic signed [31:0] held);
    return ascending ? (cand < held) : (cand > held);
  endfunction

  // Applies one accepted command to the shadow list and queues its result.
  function void note_command(command_t c);
    tksi_pkg::res_t r;
    int             pos;
    r   = '0;
    pos = -1;
    case (c.op)
      tksi_pkg::CmdClear: begin
        foreach (occupied[i]) occupied[i] = 1'b0;
      end
      tksi_pkg::CmdInsert: begin
        // First empty slot, or first held slot the candidate strictly beats.
        for (int i = 0; i < TbSlots && pos < 0; i++) begin
          if (!occupied[i]) pos = i;
          else if (outranks(c.score, score_at[i])) pos = i;
        end
        if (pos >= 0) begin
          for (int n = TbSlots - 1; n > pos; n--) begin
            occupied[n] = occupied[n - 1];
            entry_at[n] = entry_at[n - 1];
            score_at[n] = score_at[n - 1];
          end
          occupied[pos] = 1'b1;
          entry_at[pos] = c.entry;
          score_at[pos] = c.score;
          r.inserted    = 1'b1;
          r.position    = pos[3:0];
        end
      end
      tksi_pkg::CmdRead: begin
        if (occupied[c.slot]) begin
          r.rd_valid = 1'b1;
          r.rd_entry = entry_at[c.slot];
          r.rd_score = score_at[c.slot];
        end
      end
      default: ;
    endcase
    results_due.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function void check_result(tksi_pkg::res_t got);
    tksi_pkg::res_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing outstanding, expected none, got %h",
               $time, got);
      return;
    end
    want = results_due.pop_front();
    compare_field("inserted", 32'(want.inserted), 32'(got.inserted));
    compare_field("insert_position", 32'(want.position), 32'(got.position));
    compare_field("slot_valid", 32'(want.rd_valid), 32'(got.rd_valid));
    compare_field("slot_key", want.rd_entry.key, got.rd_entry.key);
    compare_field("slot_market", 32'(want.rd_entry.market), 32'(got.rd_entry.market));
    compare_field("slot_price", want.rd_entry.price, got.rd_entry.price);
    compare_field("slot_score", want.rd_score, got.rd_score);
  endfunction
endclass

module top_k_sorted_insert_tb;

  logic               clk;
  logic               rst_ni = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = tksi_pkg::CmdClear;
  logic [31:0]        item_key = '0;
  logic [7:0]         item_market = '0;
  logic [31:0]        item_price = '0;
  logic signed [31:0] item_score = '0;
  logic [3:0]         read_slot = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               inserted;
  logic [3:0]         insert_position;
  logic               slot_valid_out;
  logic [31:0]        slot_key_out;
  logic [7:0]         slot_market_out;
  logic [31:0]        slot_price_out;
  logic signed [31:0] slot_score_out;

  ranked_list_shadow list_shadow = new();

  // Idle percentages of both sides, set per phase by the main sequence.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // A long receiver hold-off is requested by bumping hold_epoch.
  int unsigned hold_epoch = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  top_k_sorted_insert dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .cmd_i             (cmd),
    .item_key_i        (item_key),
    .item_market_i     (item_market),
    .item_price_i      (item_price),
    .item_score_i      (item_score),
    .read_slot_i       (read_slot),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .inserted_o        (inserted),
    .insert_position_o (insert_position),
    .slot_valid_out_o  (slot_valid_out),
    .slot_key_out_o    (slot_key_out),
    .slot_market_out_o (slot_market_out),
    .slot_price_out_o  (slot_price_out),
    .slot_score_out_o  (slot_score_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_epoch != hold_seen) begin
      hold_seen = hold_epoch;
      hold_left = 48;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    tksi_pkg::res_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got.inserted        = inserted;
      got.position        = insert_position;
      got.rd_valid        = slot_valid_out;
      got.rd_entry.key    = slot_key_out;
      got.rd_entry.market = slot_market_out;
      got.rd_entry.price  = slot_price_out;
      got.rd_score        = slot_score_out;
      list_shadow.check_result(got);
    end
  end

  // Offers one command beat after a random gap and holds it until accepted.
  task automatic send_command(command_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c.op;
    item_key    <= c.entry.key;
    item_market <= c.entry.market;
    item_price  <= c.entry.price;
    item_score  <= c.score;
    read_slot   <= c.slot;
    do @(posedge clk); while (in_stall);
    list_shadow.note_command(c);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (list_shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_order(bit asc);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= asc;
    do @(posedge clk); while (!cfg_ready);
    list_shadow.set_order(asc);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic command_t make_command(logic [1:0] op, logic signed [31:0] score,
                                            logic [3:0] slot);
    command_t c;
    c.op           = op;
    c.entry.key    = $urandom;
    c.entry.market = 8'($urandom_range(0, 255));
    c.entry.price  = $urandom;
    c.score        = score;
    c.slot         = slot;
    return c;
  endfunction

  // Random traffic: mostly inserts and reads so the list fills up and ties and
  // rejections are common; clears are rare so the full list is seen often.
  function automatic command_t random_command();
    logic [1:0]         op;
    logic signed [31:0] score;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       op = tksi_pkg::CmdClear;
    else if (pick < 4)  op = CmdSpare;
    else if (pick < 60) op = tksi_pkg::CmdInsert;
    else                op = tksi_pkg::CmdRead;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: score = 32'sh7FFF_FFFF;
          1: score = 32'sh8000_0000;
          2: score = 32'sh0000_0000;
          default: score = -32'sd1;
        endcase
      end
      1, 2, 3, 4: score = 32'($signed($urandom_range(0, 31)) - 16) <<< 16;
      default: score = $urandom;
    endcase
    return make_command(op, score, 4'($urandom_range(0, TbSlots - 1)));
  endfunction

  task automatic run_phase(int unsigned count, int unsigned snd, int unsigned rcv,
                           bit pause_midway, bit hold_at_start);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    if (hold_at_start) hold_epoch = hold_epoch + 1;
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        release_input();
        wait_results_drained();
      end
      send_command(random_command());
    end
    release_input();
    wait_results_drained();
  endtask

  initial begin
    command_t c;
    repeat (3) @(negedge clk);
    rst_ni <= 1'b1;

    // Directed part, descending order from reset.
    send_command(make_command(tksi_pkg::CmdRead, '0, 4'd0));
    send_command(make_command(tksi_pkg::CmdRead, '0, 4'd15));
    c = make_command(tksi_pkg::CmdInsert, 32'sh7FFF_FFFF, 4'd0);
    c.entry = '1;
    send_command(c);
    c = make_command(tksi_pkg::CmdInsert, 32'sh8000_0000, 4'd0);
    c.entry = '0;
    send_command(c);
    // Equal score goes below the entry already held.
    send_command(make_command(tksi_pkg::CmdInsert, 32'sh7FFF_FFFF, 4'd0));
    c = make_command(CmdSpare, 32'shFFFF_FFFF, 4'd15);
    c.entry = '1;
    send_command(c);
    for (int s = 0; s < 3; s++)
      send_command(make_command(tksi_pkg::CmdRead, '0, 4'(s)));
    // Fill the list with the lowest score, then offer one more tie: rejected.
    for (int s = 0; s < TbSlots - 3; s++)
      send_command(make_command(tksi_pkg::CmdInsert, 32'sh8000_0000, 4'd0));
    send_command(make_command(tksi_pkg::CmdInsert, 32'sh8000_0000, 4'd0));
    send_command(make_command(tksi_pkg::CmdRead, '0, 4'd15));
    send_command(make_command(tksi_pkg::CmdClear, '0, 4'd0));
    send_command(make_command(tksi_pkg::CmdRead, '0, 4'd0));
    release_input();
    wait_results_drained();

    // Random phases, alternating the order setting, each with a different idle mix.
    write_order(1'b1);
    run_phase(560, 22, 62, 1'b1, 1'b0);
    write_order(1'b0);
    run_phase(560, 62, 22, 1'b0, 1'b0);
    write_order(1'b1);
    run_phase(580, 0, 0, 1'b0, 1'b1);

    repeat (10) @(posedge clk);
    if (list_shadow.mismatches == 0 && list_shadow.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
